/* rtl/glyph_bitmap_subpixel_filter_assert.svh */
// Assertion macros shared by the glyph filter RTL.
// Each macro is checked on the rising edge of clk and is idle while rstn is low.
`ifndef GLYPH_BITMAP_SUBPIXEL_FILTER_ASSERT_SVH
`define GLYPH_BITMAP_SUBPIXEL_FILTER_ASSERT_SVH

// cons must hold in the same cycle as ante
`define GBSF_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define GBSF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gbsf_pkg.sv */
`timescale 1ns / 1ps
package gbsf_pkg;

    // pixel_format codes
    localparam logic [1:0] FMT_LCD  = 2'd0;
    localparam logic [1:0] FMT_GRAY = 2'd1;
    localparam logic [1:0] FMT_MONO = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] REG_ROW_WIDTH    = 2'd1;
    localparam logic [1:0] REG_ROW_COUNT    = 2'd2;

    // 5-tap LCD filter, weights over 256
    localparam int NUM_TAPS = 5;
    localparam logic [6:0] TAP_WEIGHT [NUM_TAPS] = '{7'd24, 7'd56, 7'd96, 7'd56, 7'd24};

    // position of the transaction being accepted, low bits only
    typedef struct packed {
        logic [9:0] col;      // input column c
        logic [9:0] quot;     // c / 3
        logic [1:0] rem;      // c % 3
        logic [2:0] cmin;     // min(c, 4)
        logic [9:0] row;      // flipped output row
        logic       row_end;  // c is the last column of the row
        logic [3:0] run_len;  // mono texels for this byte, 1..8
    } gbsf_pos_t;

endpackage

/* rtl/glyph_bitmap_subpixel_filter.sv */
`timescale 1ns / 1ps
// Glyph bitmap to texel converter with a 5-tap LCD subpixel filter.
// Input: one bitmap byte per transaction on s_valid/s_ready (s_sample), row by
// row, no pitch padding. Output: one texel per transaction on m_valid/m_ready
// with its column, channel, flipped row and m_last_of_run on the last texel of
// an input byte. Configuration: cfg_wr_en/cfg_index/cfg_wdata, written while idle.
// An accepted byte's texels pass through the step register, then the output register.
// Throughput: one byte per cycle in LCD and gray modes while the output is not
// stalled; the last byte of a row in LCD mode holds the window while the tap
// weights slide one cell per step to produce the two trailing subpixels. A mono
// byte takes one step per unpacked texel, min(8, columns left) texels in all.
// The five-cell sample chain holds the filter window; the output register lets
// the next byte enter while a finished texel waits. When m_ready is low the
// output register holds and s_ready drops once the pending texel is blocked.
// Reset (aresetn low, synchronous) clears the position and the filter window,
// empties the pipeline and sets pixel_format 0, row_width 1, row_count 1.
module glyph_bitmap_subpixel_filter #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_ROWS  = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_value,
    output logic [9:0]  m_column,
    output logic [1:0]  m_channel,
    output logic [9:0]  m_row,
    output logic        m_last_of_run
);
    import gbsf_pkg::*;

    typedef struct packed {
        logic       emit;
        logic       last;
        logic [9:0] col;
        logic [1:0] chan;
        logic [4:0] en;
    } step_t;

    // LCD texel for step k of a byte: subpixel x = c - 2 + k
    function automatic step_t lcd_step(input logic [1:0] k, input logic [2:0] cmin,
                                       input logic [9:0] quot, input logic [1:0] rem,
                                       input logic row_end);
        step_t      st;
        logic [1:0] back;
        logic [3:0] reach;
        back    = 2'd2 - k;
        reach   = {1'b0, cmin} + {2'b00, k};
        st.emit = (reach >= 4'd2);
        st.last = row_end ? (k == 2'd2) : (k == 2'd0);
        if (rem >= back) begin
            st.col  = quot;
            st.chan = rem - back;
        end else begin
            st.col  = quot - 10'd1;
            st.chan = rem + 2'd3 - back;
        end
        // cell z holds column c - 4 + z; drop it below column 0 or when no tap reaches it
        for (int z = 0; z < NUM_TAPS; z++) begin
            st.en[z] = (({1'b0, cmin} + 4'(z)) >= 4'd4) && (4'(z) >= {2'b00, k});
        end
        return st;
    endfunction

    // configuration
    logic [1:0]  fmt_reg, fmt_next;
    logic [10:0] width_reg, width_next;
    logic [10:0] count_reg, count_next;

    // current texel step
    logic        cur_valid_reg, cur_valid_next;
    logic        cur_emit_reg, cur_emit_next;
    logic        cur_last_reg, cur_last_next;
    logic        cur_lcd_reg, cur_lcd_next;
    logic [7:0]  cur_value_reg, cur_value_next;
    logic [9:0]  cur_col_reg, cur_col_next;
    logic [1:0]  cur_chan_reg, cur_chan_next;
    logic [9:0]  cur_row_reg, cur_row_next;
    logic [4:0]  cur_en_reg, cur_en_next;

    // byte in progress
    logic        item_lcd_reg, item_lcd_next;
    logic [1:0]  item_k_reg, item_k_next;
    logic [2:0]  item_cmin_reg, item_cmin_next;
    logic [9:0]  item_quot_reg, item_quot_next;
    logic [1:0]  item_rem_reg, item_rem_next;
    logic        item_row_end_reg, item_row_end_next;
    logic [2:0]  run_left_reg, run_left_next;
    logic [7:0]  mono_bits_reg, mono_bits_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_value_reg, m_value_next;
    logic [9:0]  m_column_reg, m_column_next;
    logic [1:0]  m_channel_reg, m_channel_next;
    logic [9:0]  m_row_reg, m_row_next;
    logic        m_last_reg, m_last_next;

    gbsf_pos_t   pos;
    step_t       lcd_first, lcd_more;
    logic        out_free, step_done, accept, cont, out_load, chain_shift;
    logic [7:0]  chain_in;
    logic [7:0]  cell_sample [NUM_TAPS];
    logic [7:0]  cell_din [NUM_TAPS];
    logic [6:0]  cell_weight [NUM_TAPS];
    logic [6:0]  cell_prod [NUM_TAPS];
    logic [8:0]  fir_sum;

    // handshake and step control
    assign out_free    = !m_valid_reg || m_ready;
    assign step_done   = cur_valid_reg && (!cur_emit_reg || out_free);
    assign s_ready     = !cur_valid_reg || (step_done && (run_left_reg == 3'd0));
    assign accept      = s_valid && s_ready;
    assign cont        = step_done && (run_left_reg != 3'd0);
    assign out_load    = cur_valid_reg && cur_emit_reg && out_free;
    assign chain_shift = accept;
    assign chain_in    = s_sample;

    gbsf_pos_tracker #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_pos (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (accept),
        .pixel_format (fmt_reg),
        .row_width    (width_reg),
        .row_count    (count_reg),
        .pos          (pos)
    );

    // tap weights slide toward newer cells on the trailing steps of a row end
    always_comb begin
        for (int z = 0; z < NUM_TAPS; z++) begin
            cell_weight[z] = 7'd0;
            for (int t = 0; t < NUM_TAPS; t++) begin
                if (t + int'(item_k_reg) == z) cell_weight[z] = TAP_WEIGHT[t];
            end
        end
    end

    // filter window: newest sample in the top cell
    for (genvar z = 0; z < NUM_TAPS; z++) begin : g_tap
        if (z == NUM_TAPS - 1) begin : g_head
            assign cell_din[z] = chain_in;
        end else begin : g_body
            assign cell_din[z] = cell_sample[z + 1];
        end
        gbsf_tap_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .shift      (chain_shift),
            .sample_in  (cell_din[z]),
            .tap_en     (cur_en_reg[z]),
            .weight     (cell_weight[z]),
            .sample_out (cell_sample[z]),
            .product    (cell_prod[z])
        );
    end

    always_comb begin
        fir_sum = 9'd0;
        for (int z = 0; z < NUM_TAPS; z++) begin
            fir_sum = fir_sum + 9'(cell_prod[z]);
        end
    end

    assign lcd_first = lcd_step(2'd0, pos.cmin, pos.quot, pos.rem, pos.row_end);
    assign lcd_more  = lcd_step(item_k_reg + 2'd1, item_cmin_reg, item_quot_reg,
                                item_rem_reg, item_row_end_reg);

    // configuration writes
    always_comb begin
        fmt_next   = fmt_reg;
        width_next = width_reg;
        count_next = count_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_PIXEL_FORMAT: fmt_next   = cfg_wdata[1:0];
                REG_ROW_WIDTH:    width_next = cfg_wdata;
                REG_ROW_COUNT:    count_next = cfg_wdata;
                default:          ;
            endcase
        end
    end

    // step sequencer: load a byte's first step, then its trailing steps
    always_comb begin
        cur_valid_next    = cur_valid_reg;
        cur_emit_next     = cur_emit_reg;
        cur_last_next     = cur_last_reg;
        cur_lcd_next      = cur_lcd_reg;
        cur_value_next    = cur_value_reg;
        cur_col_next      = cur_col_reg;
        cur_chan_next     = cur_chan_reg;
        cur_row_next      = cur_row_reg;
        cur_en_next       = cur_en_reg;
        item_lcd_next     = item_lcd_reg;
        item_k_next       = item_k_reg;
        item_cmin_next    = item_cmin_reg;
        item_quot_next    = item_quot_reg;
        item_rem_next     = item_rem_reg;
        item_row_end_next = item_row_end_reg;
        run_left_next     = run_left_reg;
        mono_bits_next    = mono_bits_reg;
        if (accept) begin
            cur_valid_next    = 1'b1;
            cur_row_next      = pos.row;
            item_k_next       = 2'd0;
            item_cmin_next    = pos.cmin;
            item_quot_next    = pos.quot;
            item_rem_next     = pos.rem;
            item_row_end_next = pos.row_end;
            cur_value_next    = s_sample;
            mono_bits_next    = {s_sample[6:0], 1'b0};
            case (fmt_reg)
                FMT_LCD: begin
                    item_lcd_next = 1'b1;
                    cur_lcd_next  = 1'b1;
                    cur_emit_next = lcd_first.emit;
                    cur_last_next = lcd_first.last;
                    cur_col_next  = lcd_first.col;
                    cur_chan_next = lcd_first.chan;
                    cur_en_next   = lcd_first.en;
                    run_left_next = pos.row_end ? 3'd2 : 3'd0;
                end
                FMT_MONO: begin
                    item_lcd_next  = 1'b0;
                    cur_lcd_next   = 1'b0;
                    cur_emit_next  = 1'b1;
                    cur_last_next  = (pos.run_len == 4'd1);
                    cur_col_next   = pos.col;
                    cur_chan_next  = 2'd0;
                    cur_en_next    = '0;
                    cur_value_next = s_sample[7] ? 8'hFF : 8'h00;
                    run_left_next  = 3'(pos.run_len - 4'd1);
                end
                default: begin
                    // gray, and the unused format code
                    item_lcd_next = 1'b0;
                    cur_lcd_next  = 1'b0;
                    cur_emit_next = 1'b1;
                    cur_last_next = 1'b1;
                    cur_col_next  = pos.col;
                    cur_chan_next = 2'd0;
                    cur_en_next   = '0;
                    run_left_next = 3'd0;
                end
            endcase
        end else if (cont) begin
            run_left_next = run_left_reg - 3'd1;
            item_k_next   = item_k_reg + 2'd1;
            if (item_lcd_reg) begin
                cur_emit_next = lcd_more.emit;
                cur_last_next = lcd_more.last;
                cur_col_next  = lcd_more.col;
                cur_chan_next = lcd_more.chan;
                cur_en_next   = lcd_more.en;
            end else begin
                cur_emit_next  = 1'b1;
                cur_last_next  = (run_left_reg == 3'd1);
                cur_col_next   = cur_col_reg + 10'd1;
                cur_value_next = mono_bits_reg[7] ? 8'hFF : 8'h00;
                mono_bits_next = {mono_bits_reg[6:0], 1'b0};
            end
        end else if (step_done) begin
            cur_valid_next = 1'b0;
        end
    end

    // output register
    always_comb begin
        m_valid_next   = m_valid_reg;
        m_value_next   = m_value_reg;
        m_column_next  = m_column_reg;
        m_channel_next = m_channel_reg;
        m_row_next     = m_row_reg;
        m_last_next    = m_last_reg;
        if (out_load) begin
            m_valid_next   = 1'b1;
            m_value_next   = cur_lcd_reg ? fir_sum[7:0] : cur_value_reg;
            m_column_next  = cur_col_reg;
            m_channel_next = cur_chan_reg;
            m_row_next     = cur_row_reg;
            m_last_next    = cur_last_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg       <= FMT_LCD;
            width_reg     <= 11'd1;
            count_reg     <= 11'd1;
            cur_valid_reg <= 1'b0;
            run_left_reg  <= 3'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            fmt_reg       <= fmt_next;
            width_reg     <= width_next;
            count_reg     <= count_next;
            cur_valid_reg <= cur_valid_next;
            run_left_reg  <= run_left_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_emit_reg     <= cur_emit_next;
        cur_last_reg     <= cur_last_next;
        cur_lcd_reg      <= cur_lcd_next;
        cur_value_reg    <= cur_value_next;
        cur_col_reg      <= cur_col_next;
        cur_chan_reg     <= cur_chan_next;
        cur_row_reg      <= cur_row_next;
        cur_en_reg       <= cur_en_next;
        item_lcd_reg     <= item_lcd_next;
        item_k_reg       <= item_k_next;
        item_cmin_reg    <= item_cmin_next;
        item_quot_reg    <= item_quot_next;
        item_rem_reg     <= item_rem_next;
        item_row_end_reg <= item_row_end_next;
        mono_bits_reg    <= mono_bits_next;
        m_value_reg      <= m_value_next;
        m_column_reg     <= m_column_next;
        m_channel_reg    <= m_channel_next;
        m_row_reg        <= m_row_next;
        m_last_reg       <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_value       = m_value_reg;
    assign m_column      = m_column_reg;
    assign m_channel     = m_channel_reg;
    assign m_row         = m_row_reg;
    assign m_last_of_run = m_last_reg;

`include "glyph_bitmap_subpixel_filter_assert.svh"

    // a byte with texels still to come holds off the next transaction
    `GBSF_ASSERT_SAME(a_run_blocks_input, aclk, aresetn, cur_valid_reg && (run_left_reg != 3'd0), !s_ready, "input taken while a run is pending")
    // the texel flagged last closes its run
    `GBSF_ASSERT_SAME(a_last_ends_run, aclk, aresetn, out_load && cur_last_reg, run_left_reg == 3'd0, "last texel sent with steps left")
    // mono texels of one byte step through consecutive columns
    `GBSF_ASSERT_NEXT(a_mono_column_step, aclk, aresetn, cont && !item_lcd_reg, cur_col_reg == $past(cur_col_reg) + 10'd1, "mono column did not advance by one")

endmodule

/* rtl/gbsf_tap_cell.sv */
`timescale 1ns / 1ps
module gbsf_tap_cell (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift,
    input  logic [7:0] sample_in,
    input  logic       tap_en,
    input  logic [6:0] weight,
    output logic [7:0] sample_out,
    output logic [6:0] product
);

    logic [7:0]  sample_reg;
    logic [7:0]  sample_next;
    logic [14:0] mult;

    // one window slot; shifts toward the older end of the chain
    always_comb begin
        sample_next = shift ? sample_in : sample_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= 8'd0;
        end else begin
            sample_reg <= sample_next;
        end
    end

    // each product is truncated on its own, dropped taps give zero
    assign mult       = sample_reg * weight;
    assign product    = tap_en ? mult[14:8] : 7'd0;
    assign sample_out = sample_reg;

endmodule

/* rtl/gbsf_pos_tracker.sv */
`timescale 1ns / 1ps
module gbsf_pos_tracker #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_ROWS  = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic [1:0]         pixel_format,
    input  logic [10:0]        row_width,
    input  logic [10:0]        row_count,
    output gbsf_pkg::gbsf_pos_t pos
);
    import gbsf_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH) + 1;
    localparam int RW  = $clog2(MAX_ROWS) + 1;
    localparam int CEW = (CW > 11) ? CW : 11;
    localparam int REW = (RW > 11) ? RW : 11;

    logic [CW-1:0]  col_reg, col_next;
    logic [CW-1:0]  quot_reg, quot_next;
    logic [1:0]     rem_reg, rem_next;
    logic [RW-1:0]  row_reg, row_next;

    logic [CEW-1:0] width_ext;
    logic [REW-1:0] count_ext;
    logic [CW-1:0]  width, c, qc, left, sum;
    logic [RW-1:0]  rows, rowc, orow, row_inc;
    logic [1:0]     rc, qinc, rnew;
    logic [3:0]     run_len, adv, rsum, qinc3;
    logic           stale, wrap;
    logic [CW+9:0]  c_ext, q_ext;
    logic [RW+9:0]  orow_ext;

    // clamp the configured sizes
    assign width_ext = CEW'(row_width);
    assign count_ext = REW'(row_count);

    always_comb begin
        if (row_width == 11'd0) begin
            width = CW'(1);
        end else if (width_ext > CEW'(MAX_WIDTH)) begin
            width = CW'(MAX_WIDTH);
        end else begin
            width = CW'(width_ext);
        end
        if (row_count == 11'd0) begin
            rows = RW'(1);
        end else if (count_ext > REW'(MAX_ROWS)) begin
            rows = RW'(MAX_ROWS);
        end else begin
            rows = RW'(count_ext);
        end
    end

    // stale position after a size change restarts the row or the glyph
    assign stale = (col_reg >= width);
    assign c     = stale ? '0 : col_reg;
    assign qc    = stale ? '0 : quot_reg;
    assign rc    = stale ? 2'd0 : rem_reg;
    assign rowc  = (row_reg >= rows) ? '0 : row_reg;
    assign orow  = rows - rowc - RW'(1);

    // advance: one column, or the mono run length
    assign left    = width - c;
    assign run_len = (left > CW'(8)) ? 4'd8 : left[3:0];
    assign adv     = (pixel_format == FMT_MONO) ? run_len : 4'd1;
    assign sum     = c + CW'(adv);
    assign wrap    = (sum >= width);
    assign row_inc = rowc + RW'(1);

    // keep c / 3 and c % 3 alongside the column
    assign rsum = {2'b00, rc} + adv;
    always_comb begin
        case (rsum) inside
            [4'd0:4'd2]: qinc = 2'd0;
            [4'd3:4'd5]: qinc = 2'd1;
            [4'd6:4'd8]: qinc = 2'd2;
            default:     qinc = 2'd3;
        endcase
    end
    assign qinc3 = {1'b0, qinc, 1'b0} + {2'b00, qinc};
    assign rnew  = 2'(rsum - qinc3);

    always_comb begin
        col_next  = col_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        row_next  = row_reg;
        if (advance) begin
            if (wrap) begin
                col_next  = '0;
                quot_next = '0;
                rem_next  = 2'd0;
                row_next  = (row_inc >= rows) ? '0 : row_inc;
            end else begin
                col_next  = sum;
                quot_next = qc + CW'(qinc);
                rem_next  = rnew;
                row_next  = rowc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= 2'd0;
            row_reg  <= '0;
        end else begin
            col_reg  <= col_next;
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
            row_reg  <= row_next;
        end
    end

    // outputs carry the low ten bits
    assign c_ext    = (CW + 10)'(c);
    assign q_ext    = (CW + 10)'(qc);
    assign orow_ext = (RW + 10)'(orow);

    assign pos.col     = c_ext[9:0];
    assign pos.quot    = q_ext[9:0];
    assign pos.rem     = rc;
    assign pos.cmin    = (c >= CW'(4)) ? 3'd4 : c[2:0];
    assign pos.row     = orow_ext[9:0];
    assign pos.row_end = (c == width - CW'(1));
    assign pos.run_len = run_len;

endmodule

/* test/tb_glyph_bitmap_subpixel_filter.sv */
`timescale 1ns / 1ps
module tb_glyph_bitmap_subpixel_filter;
    import gbsf_pkg::*;

    localparam int MAX_DIM = 1024;
    localparam int STALL_LIMIT = 2000;
    // bytes in the random part; the directed table adds about 25 more
    localparam int RAND_ITEMS = 195;
    // output register plus the two trailing steps at the end of an LCD row
    localparam int SETTLE_CYCLES = 8;
    // format code three has no name in the package; it acts as gray
    localparam logic [1:0] FMT_RSVD = 2'd3;

    typedef struct packed {
        logic [7:0] value;
        logic [9:0] column;
        logic [1:0] channel;
        logic [9:0] row;
        logic       last_run;
    } texel_t;

    typedef enum bit {ROW_CFG, ROW_DATA} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  fmt;
        logic [10:0] width;
        logic [10:0] count;
        logic [7:0]  sample;
        bit          typed;
        logic [7:0]  typed_val;
    } dir_row_t;

    // DUT ports
    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_PIXEL_FORMAT;
    logic [10:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_sample = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_value;
    logic [9:0]  m_column;
    logic [1:0]  m_channel;
    logic [9:0]  m_row;
    logic        m_last_of_run;

    // predictor state
    logic [1:0]  cfg_format = FMT_LCD;
    logic [10:0] cfg_width = 11'd1;
    logic [10:0] cfg_count = 11'd1;
    logic [7:0]  hist [4] = '{default: 8'h00};
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    texel_t      pending_texels [$];

    int          errors = 0;
    int          bytes_sent = 0;
    int          tx_idle_pct = 26;
    int          rx_idle_pct = 79;
    int          stall_cycles;
    dir_row_t    dir_tab [$];
    texel_t      want;

    // random part
    int          rand_sent;
    int          n_items;
    int unsigned glyph_len;
    logic [1:0]  r_fmt;
    logic [10:0] r_width;
    logic [10:0] r_count;
    logic [7:0]  r_byte;

    glyph_bitmap_subpixel_filter #(
        .MAX_WIDTH(MAX_DIM),
        .MAX_ROWS(MAX_DIM)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_sample(s_sample),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_value(m_value),
        .m_column(m_column),
        .m_channel(m_channel),
        .m_row(m_row),
        .m_last_of_run(m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic int unsigned clamp_dim(input logic [10:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic int unsigned lcd_weight(input int z);
        case (z)
            0, 4: return 24;
            1, 3: return 56;
            default: return 96;
        endcase
    endfunction

    // win[4] is the sample at column c, win[0] the one four columns back
    function automatic logic [7:0] lcd_filter(input logic [7:0] win [5], input int c,
                                              input int x);
        int acc;
        int col;
        acc = 0;
        for (int z = 0; z < 5; z++) begin
            col = x + z - 2;
            // taps left of the row or not yet received are dropped
            if (col >= 0 && col <= c && col >= c - 4)
                acc += (win[col - c + 4] * lcd_weight(z)) >> 8;
        end
        return 8'(acc);
    endfunction

    function automatic texel_t lcd_texel(input logic [7:0] v, input int unsigned x,
                                         input logic [9:0] orow);
        return '{v, 10'(x / 3), 2'(x % 3), orow, 1'b0};
    endfunction

    task automatic predict_texels(input logic [7:0] s, input bit typed,
                                  input logic [7:0] typed_val);
        texel_t      run [8];
        logic [7:0]  win [5];
        int unsigned w;
        int unsigned rc;
        int unsigned c;
        int unsigned n;
        int unsigned adv;
        logic [9:0]  orow;
        w = clamp_dim(cfg_width);
        rc = clamp_dim(cfg_count);
        // stale position after a register change restarts the row or glyph
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= rc) row_pos = 0;
        c = col_pos;
        orow = 10'(rc - 1 - row_pos);
        n = 0;
        adv = 1;
        case (cfg_format)
            FMT_LCD: begin
                win[0] = hist[3];
                win[1] = hist[2];
                win[2] = hist[1];
                win[3] = hist[0];
                win[4] = s;
                // sample at c completes subpixel c-2
                if (c >= 2) begin
                    run[n] = lcd_texel(lcd_filter(win, c, c - 2), c - 2, orow);
                    n++;
                end
                // row end flushes the two trailing subpixels
                if (c == w - 1) begin
                    if (c >= 1) begin
                        run[n] = lcd_texel(lcd_filter(win, c, c - 1), c - 1, orow);
                        n++;
                    end
                    run[n] = lcd_texel(lcd_filter(win, c, c), c, orow);
                    n++;
                end
            end
            FMT_MONO: begin
                n = (w - c > 8) ? 8 : w - c;
                for (int b = 0; b < n; b++)
                    run[b] = '{s[7 - b] ? 8'hFF : 8'h00, 10'(c + b), 2'd0, orow, 1'b0};
                adv = n;
            end
            default: begin
                run[0] = '{s, 10'(c), 2'd0, orow, 1'b0};
                n = 1;
            end
        endcase
        for (int k = 0; k < n; k++) begin
            if (typed) run[k].value = typed_val;
            run[k].last_run = (k == n - 1);
            pending_texels.push_back(run[k]);
        end
        hist[3] = hist[2];
        hist[2] = hist[1];
        hist[1] = hist[0];
        hist[0] = s;
        col_pos = c + adv;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= rc) row_pos = 0;
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic dir_row_t cfg_row(input logic [1:0] f, input logic [10:0] w,
                                         input logic [10:0] c);
        dir_row_t r;
        r.kind = ROW_CFG;
        r.fmt = f;
        r.width = w;
        r.count = c;
        r.sample = 8'h00;
        r.typed = 1'b0;
        r.typed_val = 8'h00;
        return r;
    endfunction

    function automatic dir_row_t data_row(input logic [7:0] s, input bit typed,
                                          input logic [7:0] tv);
        dir_row_t r;
        r = cfg_row(FMT_LCD, 11'd0, 11'd0);
        r.kind = ROW_DATA;
        r.sample = s;
        r.typed = typed;
        r.typed_val = tv;
        return r;
    endfunction

    task automatic wait_idle();
        while (pending_texels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // valid stays high from one transaction to the next unless an idle gap is drawn
    task automatic send_byte(input logic [7:0] s, input bit typed, input logic [7:0] tv);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_sample <= s;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_texels(s, typed, tv);
        bytes_sent++;
        if (bytes_sent == 85) begin
            tx_idle_pct = 79;
            rx_idle_pct = 26;
        end else if (bytes_sent == 165) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    task automatic write_config(input logic [1:0] f, input logic [10:0] w,
                                input logic [10:0] c);
        s_valid <= 1'b0;
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_PIXEL_FORMAT;
        cfg_wdata <= 11'(f);
        @(posedge aclk);
        cfg_index <= REG_ROW_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_index <= REG_ROW_COUNT;
        cfg_wdata <= c;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_format = f;
        cfg_width = w;
        cfg_count = c;
    endtask

    task automatic check_field(input string name, input logic [9:0] exp_v,
                               input logic [9:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ERROR %s mismatch: expected %0d actual %0d",
                     $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // ---------------------------------------------------------------
    // receiver: random stalls and result checking
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_texels.size() == 0) begin
                $display("%0t ERROR unexpected texel: expected none actual value %0d col %0d",
                         $time, m_value, m_column);
                errors++;
            end else begin
                want = pending_texels.pop_front();
                check_field("value", 10'(want.value), 10'(m_value));
                check_field("column", want.column, m_column);
                check_field("channel", 10'(want.channel), 10'(m_channel));
                check_field("row", want.row, m_row);
                check_field("last_of_run", 10'(want.last_run), 10'(m_last_of_run));
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t ERROR watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        // reset state: LCD, one subpixel wide, one row
        dir_tab.push_back(data_row(8'hFF, 1'b1, 8'd95));
        dir_tab.push_back(data_row(8'h00, 1'b1, 8'd0));
        // gray passthrough, two rows of five
        dir_tab.push_back(cfg_row(FMT_GRAY, 11'd5, 11'd2));
        dir_tab.push_back(data_row(8'h00, 1'b1, 8'h00));
        dir_tab.push_back(data_row(8'hFF, 1'b1, 8'hFF));
        dir_tab.push_back(data_row(8'h01, 1'b1, 8'h01));
        dir_tab.push_back(data_row(8'h80, 1'b1, 8'h80));
        // unused format code behaves as gray
        dir_tab.push_back(cfg_row(FMT_RSVD, 11'd5, 11'd2));
        dir_tab.push_back(data_row(8'h55, 1'b1, 8'h55));
        // mono unpack, short tail at the row end
        dir_tab.push_back(cfg_row(FMT_MONO, 11'd11, 11'd3));
        dir_tab.push_back(data_row(8'hFF, 1'b1, 8'hFF));
        dir_tab.push_back(data_row(8'h00, 1'b1, 8'h00));
        dir_tab.push_back(data_row(8'hA5, 1'b0, 8'h00));
        // LCD filter over a full row, stale position restarts
        dir_tab.push_back(cfg_row(FMT_LCD, 11'd7, 11'd1));
        dir_tab.push_back(data_row(8'hFF, 1'b0, 8'h00));
        dir_tab.push_back(data_row(8'h00, 1'b0, 8'h00));
        dir_tab.push_back(data_row(8'h80, 1'b0, 8'h00));
        dir_tab.push_back(data_row(8'h7F, 1'b0, 8'h00));
        dir_tab.push_back(data_row(8'hFF, 1'b0, 8'h00));
        dir_tab.push_back(data_row(8'h01, 1'b0, 8'h00));
        dir_tab.push_back(data_row(8'hFE, 1'b0, 8'h00));
        // zero width and count clamp to one
        dir_tab.push_back(cfg_row(FMT_LCD, 11'd0, 11'd0));
        dir_tab.push_back(data_row(8'h3C, 1'b0, 8'h00));
        // oversized width and count clamp to the maximum
        dir_tab.push_back(cfg_row(FMT_LCD, 11'd2047, 11'd2047));
        dir_tab.push_back(data_row(8'h11, 1'b0, 8'h00));
        dir_tab.push_back(data_row(8'h22, 1'b0, 8'h00));
        dir_tab.push_back(data_row(8'h33, 1'b0, 8'h00));
        // mode change in mid row
        dir_tab.push_back(cfg_row(FMT_MONO, 11'd2047, 11'd2047));
        dir_tab.push_back(data_row(8'h81, 1'b0, 8'h00));
        // back to LCD with old samples still in the window
        dir_tab.push_back(cfg_row(FMT_LCD, 11'd2047, 11'd2047));
        dir_tab.push_back(data_row(8'h40, 1'b0, 8'h00));
        dir_tab.push_back(data_row(8'hC0, 1'b0, 8'h00));
        dir_tab.push_back(data_row(8'hFF, 1'b0, 8'h00));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG)
                write_config(dir_tab[i].fmt, dir_tab[i].width, dir_tab[i].count);
            else
                send_byte(dir_tab[i].sample, dir_tab[i].typed, dir_tab[i].typed_val);
        end

        // random glyphs, some cut short
        rand_sent = 0;
        while (rand_sent < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: r_fmt = FMT_LCD;
                4, 5:       r_fmt = FMT_GRAY;
                9:          r_fmt = FMT_RSVD;
                default:    r_fmt = FMT_MONO;
            endcase
            case ($urandom_range(0, 19))
                0:       r_width = 11'd0;
                1:       r_width = 11'd2047;
                2:       r_width = 11'd1024;
                default: r_width = 11'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 19))
                0:       r_count = 11'd0;
                1:       r_count = 11'd2047;
                2:       r_count = 11'd1024;
                default: r_count = 11'($urandom_range(1, 4));
            endcase
            write_config(r_fmt, r_width, r_count);

            glyph_len = (r_fmt == FMT_MONO) ? (clamp_dim(r_width) + 7) / 8
                                            : clamp_dim(r_width);
            glyph_len = glyph_len * clamp_dim(r_count);
            n_items = (glyph_len > 30) ? 30 : glyph_len;
            if ($urandom_range(0, 3) == 0) n_items = $urandom_range(1, n_items);
            if (n_items > RAND_ITEMS - rand_sent) n_items = RAND_ITEMS - rand_sent;

            for (int k = 0; k < n_items; k++) begin
                // one hold-off until the output side has drained
                if (rand_sent == 110) begin
                    s_valid <= 1'b0;
                    do @(posedge aclk); while (pending_texels.size() != 0);
                end
                case ($urandom_range(0, 7))
                    0:       r_byte = 8'h00;
                    1:       r_byte = 8'hFF;
                    default: r_byte = 8'($urandom_range(0, 255));
                endcase
                send_byte(r_byte, 1'b0, 8'h00);
                rand_sent++;
            end
        end

        s_valid <= 1'b0;
        wait_idle();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
